>>> rtl/core/tsst_pkg.sv
// ----------------------------------------------------------------------------
// tsst_pkg
// Shared types and constants for the tcp session state tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tsst_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned HDR_W      = 6;
  localparam int unsigned STATE_W    = 4;
  localparam int unsigned BYTES_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned TSST_FIFO_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_ADDR = 2'd0,
    CFG_INIT_PORT = 2'd1,
    CFG_RESP_ADDR = 2'd2,
    CFG_RESP_PORT = 2'd3
  } tsst_cfg_idx_t;

  // session states; the two close orders mirror each other
  typedef enum logic [STATE_W-1:0] {
    ST_CLOSED      = 4'd0,
    ST_SYN_SENT    = 4'd1,
    ST_SYN_ACK     = 4'd2,
    ST_ESTAB       = 4'd3,
    ST_I_FIN       = 4'd4,
    ST_I_FIN_ACKED = 4'd5,
    ST_I_LAST_ACK  = 4'd6,
    ST_R_FIN       = 4'd7,
    ST_R_FIN_ACKED = 4'd8,
    ST_R_LAST_ACK  = 4'd9,
    ST_DONE        = 4'd10
  } tsst_state_t;

  // classified segment passed from front to back
  typedef struct packed {
    logic             matched;
    logic             fwd;
    logic             syn;
    logic             ack;
    logic             fin;
    logic [LEN_W-1:0] pay;
  } tsst_item_t;

endpackage

`default_nettype wire

>>> rtl/core/tsst_if.sv
// ----------------------------------------------------------------------------
// tsst_if
// Valid/ready channels for segment items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsst_seg_if import tsst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] seg_src_addr;
  logic [PORT_W-1:0] seg_src_port;
  logic [ADDR_W-1:0] seg_dst_addr;
  logic [PORT_W-1:0] seg_dst_port;
  logic              syn_flag;
  logic              ack_flag;
  logic              fin_flag;
  logic [LEN_W-1:0]  seg_length;
  logic [HDR_W-1:0]  hdr_length;

  modport source (
    output valid, seg_src_addr, seg_src_port, seg_dst_addr, seg_dst_port,
           syn_flag, ack_flag, fin_flag, seg_length, hdr_length,
    input  ready
  );
  modport sink (
    input  valid, seg_src_addr, seg_src_port, seg_dst_addr, seg_dst_port,
           syn_flag, ack_flag, fin_flag, seg_length, hdr_length,
    output ready
  );
endinterface

interface tsst_res_if import tsst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               matched;
  logic [STATE_W-1:0] session_state;
  logic [BYTES_W-1:0] byte_total;
  logic               closed_flag;

  modport source (
    output valid, matched, session_state, byte_total, closed_flag,
    input  ready
  );
  modport sink (
    input  valid, matched, session_state, byte_total, closed_flag,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/tcp_session_state_tracker.sv
// ----------------------------------------------------------------------------
// tcp_session_state_tracker
// Follows one TCP session between configured initiator and responder
// endpoints and counts its payload bytes while established.
//
// Configuration: cfg_we/cfg_idx/cfg_data write the initiator address and
// port and the responder address and port; write them only while idle.
// Input: one segment item on in_seg (endpoints, SYN/ACK/FIN, lengths).
// Output: one result item on out_res for every segment: matched flag,
// session state after the segment, byte total and closed flag.
// Each accepted segment passes through the queue and then the result
// register before its result appears on out_res.
// Throughput: one segment per cycle while out_res.ready stays high; the
// front compares endpoints, a queue of FIFO_DEPTH items and the result
// register decouple it from the back, which updates the state machine and counter for each item.
// Stall: while out_res.ready is low the queue fills, and in_seg.ready drops
// once FIFO_DEPTH items and the result register are held.
// Reset: synchronous on rst_n low; endpoints clear to zero, the session is
// closed, the counter is zero and the queue and result register are empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_session_state_tracker import tsst_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = TSST_FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tsst_seg_if.sink              in_seg,
  tsst_res_if.source            out_res
);

  logic       push, push_ready;
  tsst_item_t push_item;
  logic       pop, pop_valid;
  tsst_item_t pop_item;

  tsst_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_seg     (in_seg),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  tsst_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid)
  );

  tsst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

>>> rtl/core/tsst_front.sv
// ----------------------------------------------------------------------------
// tsst_front
// Holds the endpoint registers, accepts segments and classifies direction
// and payload length.
// ----------------------------------------------------------------------------
`default_nettype none

module tsst_front import tsst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tsst_seg_if.sink              in_seg,
  output logic                  push,
  output tsst_item_t            push_item,
  input  logic                  push_ready
);

  logic [ADDR_W-1:0] init_addr_r;
  logic [PORT_W-1:0] init_port_r;
  logic [ADDR_W-1:0] resp_addr_r;
  logic [PORT_W-1:0] resp_port_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_addr_r <= '0;
      init_port_r <= '0;
      resp_addr_r <= '0;
      resp_port_r <= '0;
    end else if (cfg_we) begin
      case (tsst_cfg_idx_t'(cfg_idx))
        CFG_INIT_ADDR: init_addr_r <= cfg_data[ADDR_W-1:0];
        CFG_INIT_PORT: init_port_r <= cfg_data[PORT_W-1:0];
        CFG_RESP_ADDR: resp_addr_r <= cfg_data[ADDR_W-1:0];
        CFG_RESP_PORT: resp_port_r <= cfg_data[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  logic src_is_init, dst_is_resp, src_is_resp, dst_is_init;
  logic fwd, bwd;
  logic [LEN_W-1:0] hdr_ext;

  always_comb begin
    src_is_init = (in_seg.seg_src_addr == init_addr_r) && (in_seg.seg_src_port == init_port_r);
    dst_is_resp = (in_seg.seg_dst_addr == resp_addr_r) && (in_seg.seg_dst_port == resp_port_r);
    src_is_resp = (in_seg.seg_src_addr == resp_addr_r) && (in_seg.seg_src_port == resp_port_r);
    dst_is_init = (in_seg.seg_dst_addr == init_addr_r) && (in_seg.seg_dst_port == init_port_r);
    fwd         = src_is_init && dst_is_resp;
    bwd         = src_is_resp && dst_is_init;
    hdr_ext     = {{(LEN_W-HDR_W){1'b0}}, in_seg.hdr_length};

    push_item.matched = fwd || bwd;
    // forward wins when both directions match
    push_item.fwd     = fwd;
    push_item.syn     = in_seg.syn_flag;
    push_item.ack     = in_seg.ack_flag;
    push_item.fin     = in_seg.fin_flag;
    // payload clamps at zero for a header longer than the segment
    push_item.pay     = (in_seg.seg_length > hdr_ext) ? (in_seg.seg_length - hdr_ext) : '0;
  end

  assign in_seg.ready = push_ready;
  assign push         = in_seg.valid && push_ready;

endmodule

`default_nettype wire

>>> rtl/core/tsst_fifo.sv
// ----------------------------------------------------------------------------
// tsst_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tsst_fifo import tsst_pkg::*; #(
  parameter int unsigned DEPTH = TSST_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tsst_item_t push_item,
  output logic       push_ready,
  input  logic       pop,
  output tsst_item_t pop_item,
  output logic       pop_valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tsst_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

>>> rtl/core/tsst_back.sv
// ----------------------------------------------------------------------------
// tsst_back
// Session state machine, payload byte counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsst_back import tsst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  input  tsst_item_t pop_item,
  output logic       pop,
  tsst_res_if.source out_res
);

  tsst_state_t        state_r, state_nxt, step_state;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;

  logic               out_valid_r;
  logic               out_matched_r;
  tsst_state_t        out_state_r;
  logic [BYTES_W-1:0] out_bytes_r;

  logic fwd, bwd, syn, ack, fin;
  logic clear_bytes;

  assign pop = pop_valid && (!out_valid_r || out_res.ready);

  always_comb begin
    fwd         = pop_item.fwd;
    bwd         = !pop_item.fwd;
    syn         = pop_item.syn;
    ack         = pop_item.ack;
    fin         = pop_item.fin;
    step_state  = state_r;
    clear_bytes = 1'b0;
    case (state_r)
      ST_CLOSED: begin
        if (syn && !ack && fwd) begin
          step_state  = ST_SYN_SENT;
          clear_bytes = 1'b1;
        end
      end
      ST_SYN_SENT:    if (syn && ack && bwd)   step_state = ST_SYN_ACK;
      ST_SYN_ACK:     if (!syn && ack && fwd)  step_state = ST_ESTAB;
      ST_ESTAB:       if (fin)                 step_state = fwd ? ST_I_FIN : ST_R_FIN;
      ST_I_FIN:       if (ack && bwd)          step_state = fin ? ST_I_LAST_ACK : ST_I_FIN_ACKED;
      ST_I_FIN_ACKED: if (fin && bwd)          step_state = ST_I_LAST_ACK;
      ST_I_LAST_ACK:  if (!fin && ack && fwd)  step_state = ST_DONE;
      ST_R_FIN:       if (ack && fwd)          step_state = fin ? ST_R_LAST_ACK : ST_R_FIN_ACKED;
      ST_R_FIN_ACKED: if (fin && fwd)          step_state = ST_R_LAST_ACK;
      ST_R_LAST_ACK:  if (!fin && ack && bwd)  step_state = ST_DONE;
      default:        step_state = state_r;
    endcase

    state_nxt = state_r;
    bytes_nxt = bytes_r;
    if (pop && pop_item.matched) begin
      state_nxt = step_state;
      if (clear_bytes) begin
        bytes_nxt = '0;
      end
      // count after the transition, including the step that enters established
      if (step_state == ST_ESTAB) begin
        bytes_nxt = bytes_r + {{(BYTES_W-LEN_W){1'b0}}, pop_item.pay};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLOSED;
      bytes_r <= '0;
    end else begin
      state_r <= state_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_matched_r <= pop_item.matched;
      out_state_r   <= state_nxt;
      out_bytes_r   <= bytes_nxt;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.matched       = out_matched_r;
  assign out_res.session_state = out_state_r;
  assign out_res.byte_total    = out_bytes_r;
  assign out_res.closed_flag   = (out_state_r == ST_DONE);

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |=> state_r == ST_DONE)
    else $error("terminated session left its final state");

  a_unmatched_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !pop_item.matched |=> $stable(state_r) && $stable(bytes_r))
    else $error("unmatched item changed session state or counter");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_state_r == state_r && out_bytes_r == bytes_r)
    else $error("result register disagrees with session state");

endmodule

`default_nettype wire

>>> tb/tb_tcp_session_state_tracker.sv
// ----------------------------------------------------------------------------
// tb_tcp_session_state_tracker
// Self-checking bench for the tcp session state tracker. Segment items are
// driven through a full session lifetime (opening, a long established stretch
// with full-size payloads, one close order, the terminal state) under several
// endpoint settings. Results are checked in order against a behavioral
// tracker kept in a scoreboard, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tcp_session_state_tracker import tsst_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD   = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 4;

  typedef struct {
    logic [ADDR_W-1:0] src_addr;
    logic [PORT_W-1:0] src_port;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] dst_port;
    logic              syn;
    logic              ack;
    logic              fin;
    logic [LEN_W-1:0]  seg_len;
    logic [HDR_W-1:0]  hdr_len;
  } segment_t;

  typedef struct {
    logic               matched;
    logic [STATE_W-1:0] state;
    logic [BYTES_W-1:0] total;
    logic               closed;
  } result_t;

  class session_scoreboard;
    logic [ADDR_W-1:0]  init_addr;
    logic [PORT_W-1:0]  init_port;
    logic [ADDR_W-1:0]  resp_addr;
    logic [PORT_W-1:0]  resp_port;
    tsst_state_t        state;
    logic [BYTES_W-1:0] byte_count;
    result_t            pending_q[$];
    int                 errors;
    int                 noted;
    int                 matched_count;
    int                 checked;

    function new();
      init_addr     = '0;
      init_port     = '0;
      resp_addr     = '0;
      resp_port     = '0;
      state         = ST_CLOSED;
      byte_count    = '0;
      errors        = 0;
      noted         = 0;
      matched_count = 0;
      checked       = 0;
    endfunction

    function void set_reg(tsst_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_INIT_ADDR: init_addr = data[ADDR_W-1:0];
        CFG_INIT_PORT: init_port = data[PORT_W-1:0];
        CFG_RESP_ADDR: resp_addr = data[ADDR_W-1:0];
        CFG_RESP_PORT: resp_port = data[PORT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_fwd(segment_t s);
      return s.src_addr == init_addr && s.src_port == init_port &&
             s.dst_addr == resp_addr && s.dst_port == resp_port;
    endfunction

    function bit is_match(segment_t s);
      return is_fwd(s) || (s.src_addr == resp_addr && s.src_port == resp_port &&
                           s.dst_addr == init_addr && s.dst_port == init_port);
    endfunction

    // a matched segment that is not forward is backward
    function tsst_state_t next_state(segment_t s, bit fwd);
      tsst_state_t n;
      n = state;
      case (state)
        ST_CLOSED:      if (s.syn && !s.ack && fwd) n = ST_SYN_SENT;
        ST_SYN_SENT:    if (s.syn && s.ack && !fwd) n = ST_SYN_ACK;
        ST_SYN_ACK:     if (!s.syn && s.ack && fwd) n = ST_ESTAB;
        ST_ESTAB: begin
          if (s.fin) begin
            if (fwd) n = ST_I_FIN;
            else n = ST_R_FIN;
          end
        end
        ST_I_FIN: begin
          if (s.ack && !fwd) begin
            if (s.fin) n = ST_I_LAST_ACK;
            else n = ST_I_FIN_ACKED;
          end
        end
        ST_I_FIN_ACKED: if (s.fin && !fwd) n = ST_I_LAST_ACK;
        ST_I_LAST_ACK:  if (!s.fin && s.ack && fwd) n = ST_DONE;
        ST_R_FIN: begin
          if (s.ack && fwd) begin
            if (s.fin) n = ST_R_LAST_ACK;
            else n = ST_R_FIN_ACKED;
          end
        end
        ST_R_FIN_ACKED: if (s.fin && fwd) n = ST_R_LAST_ACK;
        ST_R_LAST_ACK:  if (!s.fin && s.ack && !fwd) n = ST_DONE;
        default: ;
      endcase
      return n;
    endfunction

    function result_t predict(segment_t s);
      result_t r;
      bit      fwd;
      bit      hit;
      fwd = is_fwd(s);
      hit = is_match(s);
      if (hit) begin
        // opening syn restarts the payload count
        if (state == ST_CLOSED && s.syn && !s.ack && fwd) byte_count = '0;
        state = next_state(s, fwd);
        if (state == ST_ESTAB && s.seg_len > s.hdr_len)
          byte_count = byte_count + (BYTES_W'(s.seg_len) - BYTES_W'(s.hdr_len));
      end
      r.matched = hit;
      r.state   = state;
      r.total   = byte_count;
      r.closed  = (state == ST_DONE);
      return r;
    endfunction

    function void note_segment(segment_t s);
      result_t r;
      r = predict(s);
      pending_q.push_back(r);
      noted++;
      if (r.matched) matched_count++;
    endfunction

    function void compare_field(string name, logic [BYTES_W-1:0] want,
                                logic [BYTES_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: matched %0b state %0d total %0h",
                 $time, got.matched, got.state, got.total);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      compare_field("matched", BYTES_W'(want.matched), BYTES_W'(got.matched));
      compare_field("session_state", BYTES_W'(want.state), BYTES_W'(got.state));
      compare_field("byte_total", want.total, got.total);
      compare_field("closed_flag", BYTES_W'(want.closed), BYTES_W'(got.closed));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tsst_seg_if in_seg ();
  tsst_res_if out_res ();

  session_scoreboard sb;
  session_scoreboard shadow;   // runs ahead on the sender side to steer stimulus

  bit hold_off_req;
  bit gaps_off;
  int burst_left;
  int wraps;

  tcp_session_state_tracker u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_seg   (in_seg),
    .out_res  (out_res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit coin(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return LEN_W'($urandom_range(0, 64));
      3, 4, 5, 6: return LEN_W'($urandom_range(40, 1500));
      default: return LEN_W'($urandom());
    endcase
  endfunction

  function automatic logic [HDR_W-1:0] rand_hdr();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return HDR_W'(60);
      default: return HDR_W'($urandom_range(0, 60));
    endcase
  endfunction

  function automatic segment_t mk_seg(bit fwd, bit syn, bit ack, bit fin,
                                      logic [LEN_W-1:0] len, logic [HDR_W-1:0] hdr);
    segment_t s;
    if (fwd) begin
      s.src_addr = shadow.init_addr;
      s.src_port = shadow.init_port;
      s.dst_addr = shadow.resp_addr;
      s.dst_port = shadow.resp_port;
    end else begin
      s.src_addr = shadow.resp_addr;
      s.src_port = shadow.resp_port;
      s.dst_addr = shadow.init_addr;
      s.dst_port = shadow.init_port;
    end
    s.syn     = syn;
    s.ack     = ack;
    s.fin     = fin;
    s.seg_len = len;
    s.hdr_len = hdr;
    return s;
  endfunction

  // segments that mostly miss the session: random, one bit off, or both ends alike
  function automatic segment_t noise_seg();
    segment_t s;
    s = mk_seg(coin(50), coin(50), coin(50), coin(50), rand_len(), rand_hdr());
    case ($urandom_range(0, 2))
      0: begin
        s.src_addr = ADDR_W'($urandom());
        s.src_port = PORT_W'($urandom());
        s.dst_addr = ADDR_W'($urandom());
        s.dst_port = PORT_W'($urandom());
      end
      1: begin
        case ($urandom_range(0, 3))
          0: s.src_addr[$urandom_range(ADDR_W-1)] ^= 1'b1;
          1: s.src_port[$urandom_range(PORT_W-1)] ^= 1'b1;
          2: s.dst_addr[$urandom_range(ADDR_W-1)] ^= 1'b1;
          default: s.dst_port[$urandom_range(PORT_W-1)] ^= 1'b1;
        endcase
      end
      default: begin
        s.dst_addr = s.src_addr;
        s.dst_port = s.src_port;
      end
    endcase
    return s;
  endfunction

  function automatic segment_t any_seg();
    if (coin(50))
      return mk_seg(coin(50), coin(50), coin(50), coin(50), rand_len(), rand_hdr());
    return noise_seg();
  endfunction

  // data traffic while established; a matched fin would end the session early
  function automatic segment_t estab_seg();
    segment_t s;
    if (coin(70)) s = mk_seg(coin(50), coin(10), coin(85), 1'b0, rand_len(), rand_hdr());
    else s = noise_seg();
    if (shadow.is_match(s)) s.fin = 1'b0;
    return s;
  endfunction

  // the segment that moves the close sequence one step on
  function automatic segment_t close_seg();
    case (shadow.state)
      ST_ESTAB:       return mk_seg(coin(50), 1'b0, coin(50), 1'b1, rand_len(), rand_hdr());
      ST_I_FIN:       return mk_seg(1'b0, 1'b0, 1'b1, coin(50), rand_len(), rand_hdr());
      ST_I_FIN_ACKED: return mk_seg(1'b0, 1'b0, coin(50), 1'b1, rand_len(), rand_hdr());
      ST_I_LAST_ACK:  return mk_seg(1'b1, 1'b0, 1'b1, 1'b0, rand_len(), rand_hdr());
      ST_R_FIN:       return mk_seg(1'b1, 1'b0, 1'b1, coin(50), rand_len(), rand_hdr());
      ST_R_FIN_ACKED: return mk_seg(1'b1, 1'b0, coin(50), 1'b1, rand_len(), rand_hdr());
      ST_R_LAST_ACK:  return mk_seg(1'b0, 1'b0, 1'b1, 1'b0, rand_len(), rand_hdr());
      default:        return any_seg();
    endcase
  endfunction

  task automatic send_seg(input segment_t s);
    int                 gap;
    logic [BYTES_W-1:0] prev_total;
    if (!gaps_off && burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = coin(20) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_seg.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    prev_total = shadow.byte_count;
    void'(shadow.predict(s));
    if (shadow.byte_count < prev_total) wraps++;
    in_seg.valid        <= 1'b1;
    in_seg.seg_src_addr <= s.src_addr;
    in_seg.seg_src_port <= s.src_port;
    in_seg.seg_dst_addr <= s.dst_addr;
    in_seg.seg_dst_port <= s.dst_port;
    in_seg.syn_flag     <= s.syn;
    in_seg.ack_flag     <= s.ack;
    in_seg.fin_flag     <= s.fin;
    in_seg.seg_length   <= s.seg_len;
    in_seg.hdr_length   <= s.hdr_len;
    @(posedge clk);
    while (!in_seg.ready) @(posedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_seg.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_endpoints(input logic [ADDR_W-1:0] ia, input logic [PORT_W-1:0] ip,
                               input logic [ADDR_W-1:0] ra, input logic [PORT_W-1:0] rp);
    logic [CFG_DATA_W-1:0] vals [4];
    tsst_cfg_idx_t         idx;
    vals[0] = CFG_DATA_W'(ia);
    vals[1] = CFG_DATA_W'(ip);
    vals[2] = CFG_DATA_W'(ra);
    vals[3] = CFG_DATA_W'(rp);
    for (int i = 0; i < 4; i++) begin
      idx = tsst_cfg_idx_t'(i);
      cfg_we   <= 1'b1;
      cfg_idx  <= idx;
      cfg_data <= vals[i];
      sb.set_reg(idx, vals[i]);
      shadow.set_reg(idx, vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    segment_t seg;
    result_t  res;
    if (rst_n && in_seg.valid && in_seg.ready) begin
      seg.src_addr = in_seg.seg_src_addr;
      seg.src_port = in_seg.seg_src_port;
      seg.dst_addr = in_seg.seg_dst_addr;
      seg.dst_port = in_seg.seg_dst_port;
      seg.syn      = in_seg.syn_flag;
      seg.ack      = in_seg.ack_flag;
      seg.fin      = in_seg.fin_flag;
      seg.seg_len  = in_seg.seg_length;
      seg.hdr_len  = in_seg.hdr_length;
      sb.note_segment(seg);
    end
    if (rst_n && out_res.valid && out_res.ready) begin
      res.matched = out_res.matched;
      res.state   = out_res.session_state;
      res.total   = out_res.byte_total;
      res.closed  = out_res.closed_flag;
      sb.check_result(res);
    end
  end

  initial begin : receiver
    int phase_left;
    int stall_pct;
    phase_left = 0;
    stall_pct  = 0;
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (phase_left <= 0) begin
        phase_left = $urandom_range(10, 80);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      phase_left--;
      out_res.ready <= !coin(stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_seg.valid && in_seg.ready) || (out_res.valid && out_res.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("tb_tcp_session_state_tracker: done, errors");
    $finish;
  end

  initial begin : stimulus
    segment_t s;
    string    closer;
    sb     = new();
    shadow = new();
    closer = "nobody";
    hold_off_req = 1'b0;
    gaps_off     = 1'b0;
    burst_left   = 0;
    wraps        = 0;
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    in_seg.valid        = 1'b0;
    in_seg.seg_src_addr = '0;
    in_seg.seg_src_port = '0;
    in_seg.seg_dst_addr = '0;
    in_seg.seg_dst_port = '0;
    in_seg.syn_flag     = 1'b0;
    in_seg.ack_flag     = 1'b0;
    in_seg.fin_flag     = 1'b0;
    in_seg.seg_length   = '0;
    in_seg.hdr_length   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all endpoints zero after reset: the all-zero segment matches both ways
    send_seg(mk_seg(1'b1, 1'b0, 1'b0, 1'b0, '0, '0));
    drain();
    set_endpoints('1, '1, '0, '0);

    s = mk_seg(1'b1, 1'b1, 1'b0, 1'b0, LEN_W'(100), HDR_W'(20));
    s.dst_port = PORT_W'(1);
    send_seg(s);                                              // one field off
    send_seg(mk_seg(1'b0, 1'b1, 1'b0, 1'b0, '0, '0));         // syn from responder
    send_seg(mk_seg(1'b1, 1'b1, 1'b1, 1'b0, '0, '0));         // syn+ack while closed
    send_seg(mk_seg(1'b1, 1'b1, 1'b0, 1'b1, '1, HDR_W'(60))); // opening syn
    send_seg(mk_seg(1'b1, 1'b1, 1'b1, 1'b0, '0, '0));
    send_seg(mk_seg(1'b0, 1'b0, 1'b1, 1'b0, '0, '0));
    send_seg(mk_seg(1'b0, 1'b1, 1'b1, 1'b0, '0, '0));         // syn+ack back
    send_seg(mk_seg(1'b1, 1'b1, 1'b1, 1'b0, '0, '0));
    send_seg(mk_seg(1'b0, 1'b0, 1'b1, 1'b0, '0, '0));
    send_seg(mk_seg(1'b1, 1'b0, 1'b1, 1'b0, LEN_W'(1000), HDR_W'(20))); // entry step counts
    send_seg(mk_seg(1'b1, 1'b0, 1'b1, 1'b0, LEN_W'(10), HDR_W'(60)));   // header longer
    send_seg(mk_seg(1'b0, 1'b0, 1'b1, 1'b0, '1, '0));
    send_seg(mk_seg(1'b0, 1'b1, 1'b0, 1'b0, LEN_W'(20), HDR_W'(20)));
    s = mk_seg(1'b1, 1'b1, 1'b1, 1'b1, '1, HDR_W'(60));
    s.dst_addr = '1;
    s.dst_port = '1;
    send_seg(s);                                              // unmatched fin ignored
    send_seg(mk_seg(1'b1, 1'b0, 1'b0, 1'b0, LEN_W'(60), HDR_W'(59)));
    send_seg(mk_seg(1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
    drain();

    set_endpoints(ADDR_W'($urandom()), PORT_W'($urandom()),
                  ADDR_W'($urandom()), PORT_W'($urandom()));
    // full-size payloads back to back
    gaps_off = 1'b1;
    repeat (40) send_seg(mk_seg(1'b1, 1'b0, 1'b1, 1'b0, '1, '0));
    gaps_off = 1'b0;
    repeat (90) send_seg(estab_seg());
    // receiver holds off while items keep coming, so the input backs up
    hold_off_req = 1'b1;
    gaps_off = 1'b1;
    repeat (16) send_seg(estab_seg());
    gaps_off = 1'b0;
    repeat (90) send_seg(estab_seg());
    drain();

    // both roles on the same endpoint: every match counts as forward
    set_endpoints(ADDR_W'($urandom()), PORT_W'($urandom()), '0, '0);
    set_endpoints(shadow.init_addr, shadow.init_port, shadow.init_addr, shadow.init_port);
    repeat (150) send_seg(estab_seg());
    drain();

    // same host, different ports
    set_endpoints(ADDR_W'($urandom()), PORT_W'($urandom()), '0, PORT_W'($urandom()));
    set_endpoints(shadow.init_addr, shadow.init_port, shadow.init_addr, shadow.resp_port);
    repeat (100) send_seg(estab_seg());

    for (int i = 0; i < 300 && shadow.state != ST_DONE; i++) begin
      if (coin(35)) send_seg(any_seg());
      else send_seg(close_seg());
      if (closer == "nobody" && shadow.state >= ST_I_FIN && shadow.state <= ST_I_LAST_ACK)
        closer = "initiator";
      if (closer == "nobody" && shadow.state >= ST_R_FIN && shadow.state <= ST_R_LAST_ACK)
        closer = "responder";
    end
    drain();

    // terminal state: nothing may move it
    set_endpoints('0, '0, '1, '1);
    repeat (120) send_seg(any_seg());
    drain();

    $display("covered %0d segments (%0d matched), %0d results checked, %0d counter wrap(s)",
             sb.noted, sb.matched_count, sb.checked, wraps);
    $display("close begun by %s, final state %0d, byte total %0h",
             closer, sb.state, sb.byte_count);
    if (sb.errors == 0) $display("tb_tcp_session_state_tracker: done, clean");
    else $display("tb_tcp_session_state_tracker: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
